[design/knapsack_dp_engine_top_assert.svh]
// Assertion macros shared by the checker of the knapsack engine.
// Depends on nothing; included by the checker file.
`ifndef KNAPSACK_DP_ENGINE_TOP_ASSERT_SVH
`define KNAPSACK_DP_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define KDE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("knapsack engine assertion failed");

// Next-cycle implication, disabled while reset is active.
`define KDE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("knapsack engine assertion failed");

`endif

[design/kde_pkg.sv]
// Package of the knapsack engine: sizes, register map, control types and helpers.
// Depends on nothing; used by every other file of the block but the assertion macros header.
package kde_pkg;

  localparam int MAX_CAPACITY = 255;
  localparam int PROFIT_BITS  = 24;
  localparam int ROW_LEN      = MAX_CAPACITY + 1;
  localparam int IDX_W        = (ROW_LEN > 2) ? $clog2(ROW_LEN) : 1;

  localparam int WEIGHT_W = 16;
  localparam int ITEM_P_W = 16;
  localparam int BEST_W   = 24;
  localparam int CAP_W    = 8;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic                REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0]    CAP_RESET    = 8'hFF;

  localparam logic [32:0] PROFIT_TOP = (33'd1 << PROFIT_BITS) - 33'd1;
  localparam logic [31:0] BEST_TOP   = 32'h00FF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_UPDATE,
    S_SEEK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic update;
    logic clear;
  } cell_ctl_t;

  function automatic logic [PROFIT_BITS-1:0] sat_add(
    input logic [PROFIT_BITS-1:0] a,
    input logic [ITEM_P_W-1:0]    p
  );
    logic [32:0] s;
    s = 33'(a) + 33'(p);
    if (s > PROFIT_TOP) begin
      return PROFIT_BITS'(PROFIT_TOP);
    end
    return PROFIT_BITS'(s);
  endfunction

  function automatic logic [BEST_W-1:0] sat_best(input logic [PROFIT_BITS-1:0] v);
    if (32'(v) > BEST_TOP) begin
      return BEST_W'(BEST_TOP);
    end
    return BEST_W'(v);
  endfunction

endpackage

[design/kde_if.sv]
// Handshake interfaces of the knapsack engine: item beats in, result beats out.
// Depends on kde_pkg for the field widths.
interface kde_item_if import kde_pkg::*;;
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] item_weight;
  logic [ITEM_P_W-1:0] item_profit;
  logic                last_item;

  modport source (output valid, item_weight, item_profit, last_item, input ready);
  modport sink   (input valid, item_weight, item_profit, last_item, output ready);
endinterface

interface kde_result_if import kde_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BEST_W-1:0] best_profit;
  logic              is_final;

  modport source (output valid, best_profit, is_final, input ready);
  modport sink   (input valid, best_profit, is_final, output ready);
endinterface

[design/kde_cell.sv]
// One cell of the profit row: holds one entry and one stage of the shift chain.
// Depends on kde_pkg for the control struct and the saturating add.
module kde_cell import kde_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctl_t              ctl_i,
  input  logic [ITEM_P_W-1:0]    profit_i,
  input  logic [PROFIT_BITS-1:0] prev_shift_i,
  input  logic                   prev_valid_i,
  output logic [PROFIT_BITS-1:0] shift_o,
  output logic                   valid_o
);

  logic [PROFIT_BITS-1:0] row_q;
  logic [PROFIT_BITS-1:0] shift_q;
  logic                   valid_q;
  logic [PROFIT_BITS-1:0] take;
  logic [PROFIT_BITS-1:0] row_d;

  always_comb begin
    take  = sat_add(shift_q, profit_i);
    row_d = (valid_q && (take > row_q)) ? take : row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (ctl_i.clear) begin
      row_q <= '0;
    end else if (ctl_i.update) begin
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= 1'b1;
    end else if (ctl_i.shift) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      shift_q <= row_q;
    end else if (ctl_i.update) begin
      shift_q <= row_d;
    end else if (ctl_i.shift) begin
      shift_q <= prev_shift_i;
    end
  end

  assign shift_o = shift_q;
  assign valid_o = valid_q;

endmodule

[design/kde_ctrl.sv]
// Sequencer of the knapsack engine: aligns the row by a fitting weight, updates it,
// shifts the reported entry to the top cell and holds the result beat. Uses kde_pkg.
module kde_ctrl import kde_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [WEIGHT_W-1:0]    item_weight_i,
  input  logic [ITEM_P_W-1:0]    item_profit_i,
  input  logic                   last_item_i,
  input  logic [CAP_W-1:0]       capacity_i,
  input  logic [PROFIT_BITS-1:0] top_shift_i,
  output cell_ctl_t              ctl_o,
  output logic [ITEM_P_W-1:0]    profit_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [BEST_W-1:0]      best_profit_o,
  output logic                   is_final_o
);

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [ITEM_P_W-1:0] profit_q;
  logic                last_q;
  logic                out_valid_q;
  logic [BEST_W-1:0]   best_q;
  logic                final_q;

  logic                accept;
  logic                fits;
  logic                emit_fire;
  logic                cnt_zero;
  logic [31:0]         cap_lim;
  logic [IDX_W-1:0]    seek_cnt;

  always_comb begin
    accept    = in_valid_i && (state_q == S_IDLE);
    fits      = 32'(item_weight_i) <= 32'(MAX_CAPACITY);
    cnt_zero  = (cnt_q == '0);
    emit_fire = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
    cap_lim   = (32'(capacity_i) > 32'(MAX_CAPACITY)) ? 32'(MAX_CAPACITY)
                                                       : 32'(capacity_i);
    seek_cnt  = IDX_W'(32'(MAX_CAPACITY) - cap_lim);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = fits ? S_ALIGN : S_SEEK;
        end
      end
      S_ALIGN: begin
        if (cnt_zero) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: state_d = S_SEEK;
      S_SEEK: begin
        if (cnt_zero) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == S_IDLE);
    ctl_o.load   = accept;
    ctl_o.shift  = ((state_q == S_ALIGN) || (state_q == S_SEEK)) && !cnt_zero;
    ctl_o.update = (state_q == S_UPDATE);
    ctl_o.clear  = emit_fire && last_q;
    cnt_d        = cnt_q;
    if (accept) begin
      cnt_d = fits ? IDX_W'(item_weight_i) : seek_cnt;
    end else if (ctl_o.update) begin
      cnt_d = seek_cnt;
    end else if (ctl_o.shift) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      profit_q <= item_profit_i;
      last_q   <= last_item_i;
    end
    if (emit_fire) begin
      best_q  <= sat_best(top_shift_i);
      final_q <= last_q;
    end
  end

  assign profit_o      = profit_q;
  assign out_valid_o   = out_valid_q;
  assign best_profit_o = best_q;
  assign is_final_o    = final_q;

endmodule

[design/knapsack_dp_engine_top.sv]
// Knapsack engine top level: a chain of MAX_CAPACITY+1 cells, the sequencer and the
// register port. When the item weight fits, the row is aligned by it and then updated;
// when it does not, the row is left unchanged and no alignment is done. The shift
// chain moves one entry a cycle, first to align by weight, then to bring the reported
// entry to the top cell. One item at a time; the next is taken the cycle after the result
// is registered. Reset clears the row, the sequencer and sets capacity to 255.
module knapsack_dp_engine_top import kde_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kde_item_if.sink              item_i,
  kde_result_if.source          result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CAP_W-1:0]       cap_q;
  logic                   reg_sel;
  cell_ctl_t              ctl;
  logic [ITEM_P_W-1:0]    profit;
  logic [PROFIT_BITS-1:0] shift_w [ROW_LEN];
  logic                   valid_w [ROW_LEN];

  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  kde_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (item_i.valid),
    .in_ready_o    (item_i.ready),
    .item_weight_i (item_i.item_weight),
    .item_profit_i (item_i.item_profit),
    .last_item_i   (item_i.last_item),
    .capacity_i    (cap_q),
    .top_shift_i   (shift_w[MAX_CAPACITY]),
    .ctl_o         (ctl),
    .profit_o      (profit),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .best_profit_o (result_o.best_profit),
    .is_final_o    (result_o.is_final)
  );

  for (genvar i = 0; i < ROW_LEN; i++) begin : g_cell
    if (i == 0) begin : g_first
      kde_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl),
        .profit_i     (profit),
        .prev_shift_i ('0),
        .prev_valid_i (1'b0),
        .shift_o      (shift_w[i]),
        .valid_o      (valid_w[i])
      );
    end else begin : g_next
      kde_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl),
        .profit_i     (profit),
        .prev_shift_i (shift_w[i-1]),
        .prev_valid_i (valid_w[i-1]),
        .shift_o      (shift_w[i]),
        .valid_o      (valid_w[i])
      );
    end
  end

endmodule

[design/kde_checker.sv]
// Port-level checker of the knapsack engine and its bind to the top level.
// Depends on kde_pkg and the assertion macros header.
`include "knapsack_dp_engine_top_assert.svh"

module kde_checker import kde_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BEST_W-1:0] best_profit_i,
  input logic              is_final_i
);

  `KDE_ASSERT_NXT(a_one_item_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `KDE_ASSERT_NXT(a_no_instant_result, clk_i, rst_ni, in_valid_i && in_ready_i, !$rose(out_valid_i))
  `KDE_ASSERT_NXT(a_result_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `KDE_ASSERT_NXT(a_payload_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(best_profit_i) && $stable(is_final_i))

endmodule

bind knapsack_dp_engine_top kde_checker u_kde_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .best_profit_i (result_o.best_profit),
  .is_final_i    (result_o.is_final)
);
